>>> design/msrf_pkg.sv
// Shared types and constants for the message slot ring FIFO.
// Used by msrf_ram and message_slot_ring_fifo_core; no dependencies.
`timescale 1ns / 1ps

package msrf_pkg;

	localparam int DEF_SLOTS      = 16;
	localparam int DEF_SLOT_BYTES = 64;

	localparam int DATA_W = 8;
	localparam int LEN_W  = 7;
	localparam int CAP_W  = 7;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_PEEK    = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_SMALL    = 3'd3,
		ST_OVERLONG = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LEN,
		S_STREAM
	} state_t;

endpackage

>>> design/msrf_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Takes its default sizes from msrf_pkg; instantiated by message_slot_ring_fifo_core.
`timescale 1ns / 1ps

module msrf_ram #(
	parameter int DEPTH = msrf_pkg::DEF_SLOTS,
	parameter int WIDTH = msrf_pkg::DATA_W,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> design/message_slot_ring_fifo_core.sv
// Message slot ring FIFO: write, release and reads or peeks of an empty ring load their result on acceptance.
// Read and peek read the length RAM on acceptance, then fetch the first byte from the byte RAM,
// then one byte per cycle out of the byte RAM while out_ready allows; a too_small read returns instead.
// One item is in flight at a time; a new item is taken once the last one is done and the output is free.
// arst_n clears pointers, occupancy, write offset, overlong flag and the output valid;
// the slot RAMs are not cleared and hold garbage until written.
`timescale 1ns / 1ps

module message_slot_ring_fifo_core #(
	parameter int SLOTS      = msrf_pkg::DEF_SLOTS,
	parameter int SLOT_BYTES = msrf_pkg::DEF_SLOT_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [msrf_pkg::DATA_W-1:0] data_in,
	input  logic                        last_in,
	input  logic [msrf_pkg::CAP_W-1:0]  reader_capacity,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [msrf_pkg::DATA_W-1:0] data_out,
	output logic [msrf_pkg::LEN_W-1:0]  msg_length,
	output logic                        last_out
);

	localparam int PW = $clog2(SLOTS);              // slot pointer
	localparam int OW = $clog2(SLOTS + 1);          // occupancy, holds SLOTS
	localparam int IW = $clog2(SLOT_BYTES + 1);     // byte offset, holds SLOT_BYTES
	localparam int AW = $clog2(SLOTS * SLOT_BYTES); // byte RAM address
	localparam int LW = msrf_pkg::LEN_W;
	localparam int DW = msrf_pkg::DATA_W;

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	msrf_pkg::state_t state_q, state_d;

	logic [PW-1:0] head_q, tail_q;
	logic [OW-1:0] occ_q;
	logic [IW-1:0] wo_q;          // write offset into the head slot
	logic          ovl_q;         // message being written has overrun its slot

	msrf_pkg::op_t           op_q;
	logic [msrf_pkg::CAP_W-1:0] cap_q;
	logic [AW-1:0]           base_q;  // byte RAM base of the tail slot
	logic [LW-1:0]           len_q;   // length being streamed
	logic [IW-1:0]           idx_q;   // byte offset whose data sits on the RAM output

	// output register
	logic              out_valid_q;
	msrf_pkg::status_t out_status_q;
	logic [DW-1:0]     out_data_q;
	logic [LW-1:0]     out_len_q;
	logic              out_last_q;

	// RAM ports
	logic          byte_we;
	logic [AW-1:0] byte_waddr, byte_raddr;
	logic [DW-1:0] byte_rdata;
	logic          len_we;
	logic [LW-1:0] len_wdata, len_rdata;

	// ------------------------------------------------------------------
	// Handshake. The output register frees up in the same cycle that a
	// transfer drains it, so results stream at one per cycle while out_ready is high and no length read is pending.
	// ------------------------------------------------------------------
	logic out_free, acc;
	msrf_pkg::op_t op_in;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == msrf_pkg::S_IDLE) && out_free;
	assign acc      = in_valid && in_ready;
	assign op_in    = msrf_pkg::op_t'(op);

	// ------------------------------------------------------------------
	// Ring bookkeeping
	// ------------------------------------------------------------------
	logic          is_full, is_empty, fits, ovl_n, commit;
	logic [IW-1:0] wo_inc;
	logic [PW-1:0] head_nxt, tail_nxt;

	assign is_full  = (occ_q == OW'(SLOTS));
	assign is_empty = (occ_q == '0);
	assign fits     = !ovl_q && (wo_q < IW'(SLOT_BYTES));
	assign ovl_n    = ovl_q || !fits;
	assign wo_inc   = wo_q + IW'(1);
	assign head_nxt = (head_q == PW'(SLOTS - 1)) ? '0 : head_q + PW'(1);
	assign tail_nxt = (tail_q == PW'(SLOTS - 1)) ? '0 : tail_q + PW'(1);

	// a last byte that did not overrun commits the head slot
	assign commit = acc && (op_in == msrf_pkg::OP_WRITE) && !is_full && last_in && !ovl_n;

	// byte RAM write: head slot at the current offset
	assign byte_we    = acc && (op_in == msrf_pkg::OP_WRITE) && !is_full && fits;
	assign byte_waddr = AW'(head_q) * AW'(SLOT_BYTES) + AW'(wo_q);

	assign len_we    = commit;
	assign len_wdata = LW'(wo_inc);

	// ------------------------------------------------------------------
	// Streaming. The byte RAM is read every cycle; when the output
	// register takes a byte short of the last, the next offset is
	// fetched; else the current one is, so the RAM output holds.
	// ------------------------------------------------------------------
	logic [LW-1:0] len_eff;
	logic          too_small, beat_last, adv;
	logic [IW-1:0] rd_off;

	assign len_eff   = (len_rdata > LW'(SLOT_BYTES)) ? LW'(SLOT_BYTES) : len_rdata;
	assign too_small = (op_q == msrf_pkg::OP_READ) && (len_rdata > cap_q);
	assign beat_last = (LW'(idx_q) + LW'(1) >= len_q);
	assign adv       = (state_q == msrf_pkg::S_STREAM) && out_free;
	assign rd_off    = (adv && !beat_last) ? idx_q + IW'(1) : idx_q;
	assign byte_raddr = base_q + AW'(rd_off);

	// ------------------------------------------------------------------
	// Next state and output register load
	// ------------------------------------------------------------------
	logic              load;
	msrf_pkg::status_t ld_status;
	logic [DW-1:0]     ld_data;
	logic [LW-1:0]     ld_len;
	logic              ld_last;
	logic              dequeue;

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		ld_status = msrf_pkg::ST_OK;
		ld_data   = '0;
		ld_len    = '0;
		ld_last   = 1'b1;
		dequeue   = 1'b0;
		case (state_q)
			msrf_pkg::S_IDLE: begin
				if (acc) begin
					load = 1'b1;
					case (op_in)
						msrf_pkg::OP_WRITE: begin
							if (is_full) begin
								ld_status = msrf_pkg::ST_FULL;
							end else if (ovl_n) begin
								ld_status = msrf_pkg::ST_OVERLONG;
							end
						end
						msrf_pkg::OP_RELEASE: begin
							if (is_empty) begin
								ld_status = msrf_pkg::ST_EMPTY;
							end else begin
								dequeue = 1'b1;
							end
						end
						default: begin
							// read or peek
							if (is_empty) begin
								ld_status = msrf_pkg::ST_EMPTY;
							end else begin
								load    = 1'b0;
								state_d = msrf_pkg::S_LEN;
							end
						end
					endcase
				end
			end
			msrf_pkg::S_LEN: begin
				// length RAM output is valid; first byte fetch is under way
				if (too_small) begin
					if (out_free) begin
						load      = 1'b1;
						ld_status = msrf_pkg::ST_SMALL;
						ld_len    = len_rdata;
						state_d   = msrf_pkg::S_IDLE;
					end
				end else begin
					state_d = msrf_pkg::S_STREAM;
				end
			end
			msrf_pkg::S_STREAM: begin
				if (adv) begin
					load    = 1'b1;
					ld_data = byte_rdata;
					ld_len  = len_q;
					ld_last = beat_last;
					if (beat_last) begin
						state_d = msrf_pkg::S_IDLE;
						dequeue = (op_q == msrf_pkg::OP_READ);
					end
				end
			end
			default: begin
				state_d = msrf_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msrf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ring pointers, occupancy and write progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
			wo_q   <= '0;
			ovl_q  <= 1'b0;
		end else begin
			if (acc && (op_in == msrf_pkg::OP_WRITE) && !is_full) begin
				if (last_in) begin
					wo_q  <= '0;
					ovl_q <= 1'b0;
				end else begin
					ovl_q <= ovl_n;
					if (fits) begin
						wo_q <= wo_inc;
					end
				end
			end
			if (commit) begin
				head_q <= head_nxt;
			end
			if (dequeue) begin
				tail_q <= tail_nxt;
			end
			// commit and dequeue never fall in the same cycle
			if (commit) begin
				occ_q <= occ_q + OW'(1);
			end else if (dequeue) begin
				occ_q <= occ_q - OW'(1);
			end
		end
	end

	// per-item context, no reset needed
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= op_in;
			cap_q  <= reader_capacity;
			base_q <= AW'(tail_q) * AW'(SLOT_BYTES);
		end
		if (state_q == msrf_pkg::S_LEN) begin
			len_q <= len_eff;
			idx_q <= '0;
		end else if (adv && !beat_last) begin
			idx_q <= idx_q + IW'(1);
		end else if (acc) begin
			idx_q <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= ld_status;
			out_data_q   <= ld_data;
			out_len_q    <= ld_len;
			out_last_q   <= ld_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign data_out   = out_data_q;
	assign msg_length = out_len_q;
	assign last_out   = out_last_q;

	// ------------------------------------------------------------------
	// Slot storage
	// ------------------------------------------------------------------
	msrf_ram #(
		.DEPTH (SLOTS * SLOT_BYTES),
		.WIDTH (DW)
	) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (byte_waddr),
		.wdata (data_in),
		.raddr (byte_raddr),
		.rdata (byte_rdata)
	);

	// length RAM is always read at the tail slot
	msrf_ram #(
		.DEPTH (SLOTS),
		.WIDTH (LW)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (head_q),
		.wdata (len_wdata),
		.raddr (tail_q),
		.rdata (len_rdata)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(SLOTS))
		else $error("occupancy above slot count");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0 || occ_q == OW'(SLOTS)) |-> (head_q == tail_q))
		else $error("head and tail disagree with occupancy");

	a_ovl_offset: assert property (@(posedge clk) disable iff (!arst_n)
		ovl_q |-> (wo_q == IW'(SLOT_BYTES)))
		else $error("overlong flag without a full slot");

	a_stream_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msrf_pkg::S_STREAM && len_q != '0) |-> (LW'(idx_q) < len_q))
		else $error("stream offset past message length");

	a_commit_occ: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (occ_q == $past(occ_q) + OW'(1)))
		else $error("commit did not bump occupancy");

endmodule
